/* design/qcn_pkg.sv */
// qcn_pkg: shared types, codes and fixed point helpers for the quadrant cursor navigator.
// No dependencies; used by the channel interfaces and the top level.
package qcn_pkg;

  localparam int unsigned QW = 17;           // Q1.16 value width
  typedef logic [QW-1:0] q_t;

  localparam q_t Q_ONE    = q_t'(65536);
  localparam q_t Q_HALF   = q_t'(32768);
  localparam q_t SPAN_MAX = q_t'(131071);

  // register reset values
  localparam q_t RESCALE_RST = q_t'(32768);
  localparam q_t MOVE_RST    = q_t'(32768);
  localparam q_t MIN_RST     = q_t'(655);
  localparam q_t LOCAL_RST   = q_t'(8192);

  // register indexes (byte address = 4 * index)
  localparam int unsigned AW = 4;
  localparam logic [1:0] REG_RESCALE = 2'd0;
  localparam logic [1:0] REG_MOVE    = 2'd1;
  localparam logic [1:0] REG_MIN     = 2'd2;
  localparam logic [1:0] REG_LOCAL   = 2'd3;

  // key modes
  typedef logic [2:0] mode_t;
  localparam mode_t MODE_RESET  = 3'd0;
  localparam mode_t MODE_LOCAL  = 3'd1;
  localparam mode_t MODE_UP     = 3'd2;
  localparam mode_t MODE_DOWN   = 3'd3;
  localparam mode_t MODE_LEFT   = 3'd4;
  localparam mode_t MODE_RIGHT  = 3'd5;
  localparam mode_t MODE_CENTRE = 3'd6;

  // last axis moved
  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_CENTRE = 2'd0;
  localparam axis_t AXIS_X      = 2'd1;
  localparam axis_t AXIS_Y      = 2'd2;

  // truncated Q1.16 product, saturated to the 17-bit range
  function automatic q_t qmul(input q_t a, input q_t b);
    logic [2*QW-1:0] p;
    p = a * b;
    return p[2*QW-1] ? SPAN_MAX : p[2*QW-2:16];
  endfunction

endpackage

/* design/qcn_if.sv */
// qcn_if: valid/ready channel interfaces for key events and cursor positions.
// Depends on qcn_pkg for payload types.
interface qcn_in_if;
  logic           valid;
  logic           ready;
  qcn_pkg::mode_t mode;
  logic           pressed;

  modport source (output valid, output mode, output pressed, input ready);
  modport sink   (input valid, input mode, input pressed, output ready);
endinterface

interface qcn_out_if;
  logic        valid;
  logic        ready;
  qcn_pkg::q_t out_x;
  qcn_pkg::q_t out_y;

  modport source (output valid, output out_x, output out_y, input ready);
  modport sink   (input valid, input out_x, input out_y, output ready);
endinterface

/* design/quadrant_cursor_navigator.sv */
// quadrant_cursor_navigator: keyboard cursor that homes in on a point by subdivision.
// Depends on qcn_pkg and the qcn_in_if / qcn_out_if channel interfaces.
//
//   channel  | dir | payload                 | handshake
//   ---------+-----+-------------------------+------------------------------
//   in_i     | in  | mode[2:0], pressed      | valid/ready transfer
//   out_o    | out | out_x[16:0], out_y[16:0]| valid/ready transfer
//   apb      | in  | 4 regs at 0x0,4,8,C     | psel/penable/pwrite, pready=1
//
// Two register stages: a key event lands in the input register; the state update
// plus result load then happen at one edge once the result register is free.
// Result valid rises at that edge. One event per cycle is sustained while the
// output is not stalled. The limiting path is one 17x17 multiply plus add and
// clamp.
// A stalled output holds the result register and the input register; input
// ready stays high while the input register is empty or can drain.
// rst_ni (async, active low) restores cursor, steps, last axis and registers.
module quadrant_cursor_navigator (
  input  logic               clk_i,
  input  logic               rst_ni,
  qcn_in_if.sink             in_i,
  qcn_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [qcn_pkg::AW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  qcn_pkg::q_t rescale_q, move_q, min_q, local_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rescale_q <= qcn_pkg::RESCALE_RST;
      move_q    <= qcn_pkg::MOVE_RST;
      min_q     <= qcn_pkg::MIN_RST;
      local_q   <= qcn_pkg::LOCAL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        qcn_pkg::REG_RESCALE: rescale_q <= pwdata[qcn_pkg::QW-1:0];
        qcn_pkg::REG_MOVE:    move_q    <= pwdata[qcn_pkg::QW-1:0];
        qcn_pkg::REG_MIN:     min_q     <= pwdata[qcn_pkg::QW-1:0];
        qcn_pkg::REG_LOCAL:   local_q   <= pwdata[qcn_pkg::QW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      qcn_pkg::REG_RESCALE: prdata[qcn_pkg::QW-1:0] = rescale_q;
      qcn_pkg::REG_MOVE:    prdata[qcn_pkg::QW-1:0] = move_q;
      qcn_pkg::REG_MIN:     prdata[qcn_pkg::QW-1:0] = min_q;
      qcn_pkg::REG_LOCAL:   prdata[qcn_pkg::QW-1:0] = local_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: input register feeds result register
  // ---------------------------------------------------------------------------
  logic           in_vld_q;
  qcn_pkg::mode_t mode_q;
  logic           pressed_q;
  logic           out_vld_q;
  qcn_pkg::q_t    out_x_q, out_y_q;
  logic           load_ok;   // result register free this cycle
  logic           fire;      // event in input register is processed

  assign load_ok     = !out_vld_q || out_o.ready;
  assign fire        = in_vld_q && load_ok;
  assign in_i.ready  = !in_vld_q || load_ok;

  assign out_o.valid = out_vld_q;
  assign out_o.out_x = out_x_q;
  assign out_o.out_y = out_y_q;

  // ---------------------------------------------------------------------------
  // navigation state and its update
  // ---------------------------------------------------------------------------
  qcn_pkg::q_t   cur_x_q, cur_y_q, span_x_q, span_y_q;
  qcn_pkg::axis_t last_q;

  qcn_pkg::q_t    cur_x_d, cur_y_d, span_x_d, span_y_d;
  qcn_pkg::axis_t last_d;
  logic           emit;

  // single shared move path: only one axis moves per event
  qcn_pkg::q_t    mv_pos, mv_span, mv_off, mv_res;
  logic [qcn_pkg::QW:0] mv_sum;
  logic           mv_neg, is_dir;
  qcn_pkg::axis_t axis;
  qcn_pkg::q_t    shr_x, shr_y, sx, sy;
  logic           shrink_x, shrink_y;

  always_comb begin
    axis   = qcn_pkg::AXIS_CENTRE;
    mv_neg = 1'b0;
    is_dir = 1'b0;
    case (mode_q)
      qcn_pkg::MODE_UP:     begin axis = qcn_pkg::AXIS_Y; mv_neg = 1'b1; is_dir = 1'b1; end
      qcn_pkg::MODE_DOWN:   begin axis = qcn_pkg::AXIS_Y; is_dir = 1'b1; end
      qcn_pkg::MODE_LEFT:   begin axis = qcn_pkg::AXIS_X; mv_neg = 1'b1; is_dir = 1'b1; end
      qcn_pkg::MODE_RIGHT:  begin axis = qcn_pkg::AXIS_X; is_dir = 1'b1; end
      qcn_pkg::MODE_CENTRE: is_dir = 1'b1;
      default: ;
    endcase

    mv_pos  = (axis == qcn_pkg::AXIS_Y) ? cur_y_q  : cur_x_q;
    mv_span = (axis == qcn_pkg::AXIS_Y) ? span_y_q : span_x_q;
    mv_off  = qcn_pkg::qmul(move_q, mv_span);
    mv_sum  = {1'b0, mv_pos} + {1'b0, mv_off};
    if (mv_neg) begin
      mv_res = (mv_off >= mv_pos) ? '0 : mv_pos - mv_off;
    end else begin
      mv_res = (mv_sum > {1'b0, qcn_pkg::Q_ONE}) ? qcn_pkg::Q_ONE
                                                   : mv_sum[qcn_pkg::QW-1:0];
    end

    // repeated axis or centre shrinks both steps
    shrink_x = (axis == qcn_pkg::AXIS_X) || (axis == qcn_pkg::AXIS_CENTRE) || (axis == last_q);
    shrink_y = (axis == qcn_pkg::AXIS_Y) || (axis == qcn_pkg::AXIS_CENTRE) || (axis == last_q);
    shr_x    = qcn_pkg::qmul(span_x_q, rescale_q);
    shr_y    = qcn_pkg::qmul(span_y_q, rescale_q);
    sx       = shrink_x ? shr_x : span_x_q;
    sy       = shrink_y ? shr_y : span_y_q;

    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    span_x_d = span_x_q;
    span_y_d = span_y_q;
    last_d   = last_q;
    emit     = 1'b0;

    if (pressed_q) begin
      if (mode_q == qcn_pkg::MODE_RESET) begin
        cur_x_d  = qcn_pkg::Q_HALF;
        cur_y_d  = qcn_pkg::Q_HALF;
        span_x_d = qcn_pkg::Q_HALF;
        span_y_d = qcn_pkg::Q_HALF;
        last_d   = qcn_pkg::AXIS_CENTRE;
        emit     = 1'b1;
      end else if (mode_q == qcn_pkg::MODE_LOCAL) begin
        span_x_d = local_q;
        span_y_d = local_q;
        emit     = 1'b1;
      end else if (is_dir) begin
        if (axis == qcn_pkg::AXIS_X) cur_x_d = mv_res;
        if (axis == qcn_pkg::AXIS_Y) cur_y_d = mv_res;
        span_x_d = (sx < min_q) ? min_q : sx;
        span_y_d = (sy < min_q) ? min_q : sy;
        last_d   = axis;
        emit     = 1'b1;
      end
    end
  end

  // control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      cur_x_q   <= qcn_pkg::Q_HALF;
      cur_y_q   <= qcn_pkg::Q_HALF;
      span_x_q  <= qcn_pkg::Q_HALF;
      span_y_q  <= qcn_pkg::Q_HALF;
      last_q    <= qcn_pkg::AXIS_CENTRE;
    end else begin
      if (in_i.ready) in_vld_q <= in_i.valid;
      if (load_ok) out_vld_q <= in_vld_q && emit;
      if (fire) begin
        cur_x_q  <= cur_x_d;
        cur_y_q  <= cur_y_d;
        span_x_q <= span_x_d;
        span_y_q <= span_y_d;
        last_q   <= last_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      mode_q    <= in_i.mode;
      pressed_q <= in_i.pressed;
    end
    if (fire) begin
      out_x_q <= cur_x_d;
      out_y_q <= cur_y_d;
    end
  end

endmodule

/* bench/tb_top.sv */
// tb_top: self-checking bench for quadrant_cursor_navigator; key events in, cursor positions out.
// Depends on qcn_pkg, the qcn_in_if / qcn_out_if channels and the top level in design/.
// A built-in tracker predicts each position; registers are set and read back over APB.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT       = 38;    // chance of an idle cycle on either side
  localparam int unsigned STALL_LIMIT    = 1000;  // cycles without any transfer
  localparam int unsigned SETTLE_CYCLES  = 4;     // two pipeline stages plus margin
  localparam int unsigned RANDOM_PHASES  = 5;
  localparam int unsigned KEYS_PER_PHASE = 170;   // acted-on presses per phase
  localparam qcn_pkg::mode_t MODE_UNUSED = qcn_pkg::mode_t'(7);

  // ---------------------------------------------------------------------------
  // Clock, reset, APB and the two channels
  // ---------------------------------------------------------------------------
  logic                   clk;
  logic                   rst_n;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [qcn_pkg::AW-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  qcn_in_if  key_if ();
  qcn_out_if pos_if ();

  quadrant_cursor_navigator u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (key_if),
    .out_o   (pos_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Cursor tracker: our own copy of the registers and navigation state
  // ---------------------------------------------------------------------------
  qcn_pkg::q_t    cfg_rescale, cfg_move, cfg_min, cfg_local;
  qcn_pkg::q_t    cur_x, cur_y, span_x, span_y;
  qcn_pkg::axis_t last_axis;

  typedef struct packed {
    qcn_pkg::q_t x;
    qcn_pkg::q_t y;
  } cursor_pos_t;

  cursor_pos_t pending_pos[$];   // positions still owed by the block, oldest first

  int  errors;
  int  keys_acted;
  int  keys_ignored;
  int  positions_checked;
  int  reg_writes;
  int  settings_used;
  int  stall_cycles;
  bit  steady;                   // when set, neither side idles

  // Q1.16 product, truncated, saturating at the largest 17-bit step.
  function automatic qcn_pkg::q_t q_product(qcn_pkg::q_t a, qcn_pkg::q_t b);
    logic [2*qcn_pkg::QW-1:0] full;
    full = {{qcn_pkg::QW{1'b0}}, a} * {{qcn_pkg::QW{1'b0}}, b};
    full = full >> 16;
    return (full > qcn_pkg::SPAN_MAX) ? qcn_pkg::SPAN_MAX : full[qcn_pkg::QW-1:0];
  endfunction

  // Shift a position by cfg_move * span, clamped to 0..1.
  function automatic qcn_pkg::q_t nudge(qcn_pkg::q_t pos, qcn_pkg::q_t span,
                                        bit toward_zero);
    qcn_pkg::q_t          off;
    logic [qcn_pkg::QW:0] sum;
    off = q_product(cfg_move, span);
    if (toward_zero) return (off >= pos) ? '0 : qcn_pkg::q_t'(pos - off);
    sum = pos + off;
    return (sum > qcn_pkg::Q_ONE) ? qcn_pkg::Q_ONE : sum[qcn_pkg::QW-1:0];
  endfunction

  function automatic qcn_pkg::q_t floor_span(qcn_pkg::q_t s);
    return (s < cfg_min) ? cfg_min : s;
  endfunction

  function automatic void home_cursor();
    cur_x     = qcn_pkg::Q_HALF;
    cur_y     = qcn_pkg::Q_HALF;
    span_x    = qcn_pkg::Q_HALF;
    span_y    = qcn_pkg::Q_HALF;
    last_axis = qcn_pkg::AXIS_CENTRE;
  endfunction

  // Move along one axis (or none for centre) and shrink steps.
  // Repeating the previous axis, or centre, shrinks both steps.
  function automatic void steer(qcn_pkg::axis_t axis, bit toward_zero);
    qcn_pkg::q_t nx, ny, sx, sy;
    nx = cur_x;
    ny = cur_y;
    sx = span_x;
    sy = span_y;
    if (axis == qcn_pkg::AXIS_X) begin
      nx = nudge(cur_x, span_x, toward_zero);
      sx = q_product(span_x, cfg_rescale);
    end else if (axis == qcn_pkg::AXIS_Y) begin
      ny = nudge(cur_y, span_y, toward_zero);
      sy = q_product(span_y, cfg_rescale);
    end
    if (axis == qcn_pkg::AXIS_CENTRE || axis == last_axis) begin
      sx = q_product(span_x, cfg_rescale);
      sy = q_product(span_y, cfg_rescale);
    end
    last_axis = axis;
    cur_x     = nx;
    cur_y     = ny;
    span_x    = floor_span(sx);
    span_y    = floor_span(sy);
  endfunction

  // Apply one key event; returns 1 when it produces a position.
  // Releases and the unused mode leave everything untouched.
  function automatic bit track_key(qcn_pkg::mode_t m, logic p);
    if (!p) return 1'b0;
    case (m)
      qcn_pkg::MODE_RESET:  home_cursor();
      qcn_pkg::MODE_LOCAL: begin
        span_x = cfg_local;      // no floor here
        span_y = cfg_local;
      end
      qcn_pkg::MODE_UP:     steer(qcn_pkg::AXIS_Y, 1'b1);
      qcn_pkg::MODE_DOWN:   steer(qcn_pkg::AXIS_Y, 1'b0);
      qcn_pkg::MODE_LEFT:   steer(qcn_pkg::AXIS_X, 1'b1);
      qcn_pkg::MODE_RIGHT:  steer(qcn_pkg::AXIS_X, 1'b0);
      qcn_pkg::MODE_CENTRE: steer(qcn_pkg::AXIS_CENTRE, 1'b0);
      default:              return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Transfer monitor: check each position first, then book each accepted key.
  // A position can never belong to a key accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_positions
    cursor_pos_t want;
    if (rst_n) begin
      if (pos_if.valid && pos_if.ready) begin
        positions_checked++;
        if (pending_pos.size() == 0) begin
          errors++;
          $display("%0t: position with none pending, expected none actual x=%0d y=%0d",
                   $time, pos_if.out_x, pos_if.out_y);
        end else begin
          want = pending_pos.pop_front();
          if (pos_if.out_x !== want.x) begin
            errors++;
            $display("%0t: out_x mismatch, expected %0d actual %0d",
                     $time, want.x, pos_if.out_x);
          end
          if (pos_if.out_y !== want.y) begin
            errors++;
            $display("%0t: out_y mismatch, expected %0d actual %0d",
                     $time, want.y, pos_if.out_y);
          end
        end
      end
      if (key_if.valid && key_if.ready) begin
        if (track_key(key_if.mode, key_if.pressed)) begin
          pending_pos.push_back('{x: cur_x, y: cur_y});
          keys_acted++;
        end else begin
          keys_ignored++;
        end
      end
    end
  end

  // Position sink: random back-pressure unless a steady stretch is running.
  always @(posedge clk) begin
    pos_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Watchdog: any key, position or APB transfer counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((key_if.valid && key_if.ready) || (pos_if.valid && pos_if.ready) ||
          (psel && penable && pready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d positions pending",
                 $time, stall_cycles, pending_pos.size());
        $display("** quadrant_cursor_navigator: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // One key transfer, preceded by random idle cycles. valid stays high on
  // return; the next send or a settle drives it in the same step.
  task automatic send_key(qcn_pkg::mode_t m, logic p);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      key_if.valid   <= 1'b0;
      key_if.mode    <= qcn_pkg::mode_t'($urandom_range(7));
      key_if.pressed <= 1'($urandom_range(1));
      @(posedge clk);
    end
    key_if.valid   <= 1'b1;
    key_if.mode    <= m;
    key_if.pressed <= p;
    do @(posedge clk); while (key_if.ready !== 1'b1);
  endtask

  // Stop sending, collect every owed position, then let the pipe empty
  // (a release may still be in flight with nothing to show for it).
  // The first edge lets the monitor book the last accepted key.
  task automatic settle();
    key_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_pos.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write (setup + access), then read back the same register.
  task automatic apb_write(logic [1:0] idx, qcn_pkg::q_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {15'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      qcn_pkg::REG_RESCALE: cfg_rescale = value;
      qcn_pkg::REG_MOVE:    cfg_move    = value;
      qcn_pkg::REG_MIN:     cfg_min     = value;
      default:              cfg_local   = value;
    endcase
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {15'b0, value}) begin
      errors++;
      $display("%0t: readback of register %0d, expected %0d actual %0d",
               $time, idx, value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(qcn_pkg::q_t rescale_v, qcn_pkg::q_t move_v,
                            qcn_pkg::q_t floor_v, qcn_pkg::q_t local_v);
    settle();
    apb_write(qcn_pkg::REG_RESCALE, rescale_v);
    apb_write(qcn_pkg::REG_MOVE, move_v);
    apb_write(qcn_pkg::REG_MIN, floor_v);
    apb_write(qcn_pkg::REG_LOCAL, local_v);
    settings_used++;
  endtask

  // Random register value: mostly in a useful band, with the extremes mixed in.
  function automatic qcn_pkg::q_t pick_setting(int unsigned lo, int unsigned hi);
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8)  return '0;
    if (roll < 16) return qcn_pkg::Q_ONE;
    if (roll < 20) return qcn_pkg::SPAN_MAX;
    if (roll < 26) return qcn_pkg::q_t'($urandom_range(131071));
    return qcn_pkg::q_t'($urandom_range(hi, lo));
  endfunction

  // Acted-on key: mostly directions, sometimes centre, local or a restart.
  function automatic qcn_pkg::mode_t pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 3)  return qcn_pkg::MODE_RESET;
    if (roll < 9)  return qcn_pkg::MODE_LOCAL;
    if (roll < 17) return qcn_pkg::MODE_CENTRE;
    return qcn_pkg::mode_t'($urandom_range(qcn_pkg::MODE_RIGHT, qcn_pkg::MODE_UP));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values: every mode, an axis repeat, releases, unused mode.
  task automatic test_default_keys();
    send_key(qcn_pkg::MODE_CENTRE, 1'b1);
    send_key(qcn_pkg::MODE_UP, 1'b1);
    send_key(qcn_pkg::MODE_DOWN, 1'b1);       // same axis again: both steps shrink
    send_key(qcn_pkg::MODE_LEFT, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b1);
    send_key(qcn_pkg::MODE_LOCAL, 1'b1);
    send_key(qcn_pkg::MODE_RESET, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b0);      // release: ignored
    send_key(MODE_UNUSED, 1'b1);              // unused mode: ignored
    send_key(MODE_UNUSED, 1'b0);
  endtask

  // Unit factors keep the step at one half, so the cursor hits both edges.
  task automatic test_edge_clamp();
    set_config(qcn_pkg::Q_ONE, qcn_pkg::Q_ONE, '0, qcn_pkg::Q_ONE);
    send_key(qcn_pkg::MODE_RESET, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b1);      // past the right edge
    send_key(qcn_pkg::MODE_LEFT, 1'b1);
    send_key(qcn_pkg::MODE_LEFT, 1'b1);
    send_key(qcn_pkg::MODE_LEFT, 1'b1);       // past the left edge
    send_key(qcn_pkg::MODE_UP, 1'b1);
    send_key(qcn_pkg::MODE_UP, 1'b1);
    send_key(qcn_pkg::MODE_UP, 1'b1);
    send_key(qcn_pkg::MODE_DOWN, 1'b1);
  endtask

  // All registers at their top value: step products saturate.
  task automatic test_saturation();
    set_config(qcn_pkg::SPAN_MAX, qcn_pkg::SPAN_MAX, qcn_pkg::SPAN_MAX, qcn_pkg::SPAN_MAX);
    send_key(qcn_pkg::MODE_LOCAL, 1'b1);
    send_key(qcn_pkg::MODE_CENTRE, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b1);
    send_key(qcn_pkg::MODE_UP, 1'b1);
  endtask

  // All registers zero: no movement, steps collapse to zero.
  task automatic test_zero_factors();
    set_config('0, '0, '0, '0);
    send_key(qcn_pkg::MODE_LOCAL, 1'b1);
    send_key(qcn_pkg::MODE_RIGHT, 1'b1);
    send_key(qcn_pkg::MODE_CENTRE, 1'b1);
  endtask

  // Random phases under fresh settings; one phase runs without idling.
  // Most traffic is acted-on presses, the rest releases and the unused mode.
  task automatic test_random_walk();
    int unsigned roll;
    int          acted;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0) begin
        set_config(qcn_pkg::RESCALE_RST, qcn_pkg::MOVE_RST, qcn_pkg::MIN_RST,
                   qcn_pkg::LOCAL_RST);
      end else begin
        set_config(pick_setting(16384, 65536), pick_setting(4096, 65536),
                   pick_setting(0, 2048), pick_setting(512, 65536));
      end
      steady = (phase == 2);
      acted  = 0;
      while (acted < KEYS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          send_key(qcn_pkg::mode_t'($urandom_range(7)), 1'b0);
        end else if (roll < 13) begin
          send_key(MODE_UNUSED, 1'b1);
        end else begin
          send_key(pick_key(), 1'b1);
          acted++;
        end
      end
    end
    steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    errors            = 0;
    keys_acted        = 0;
    keys_ignored      = 0;
    positions_checked = 0;
    reg_writes        = 0;
    settings_used     = 1;    // reset values count as the first setting
    stall_cycles      = 0;
    steady            = 1'b0;
    cfg_rescale       = qcn_pkg::RESCALE_RST;
    cfg_move          = qcn_pkg::MOVE_RST;
    cfg_min           = qcn_pkg::MIN_RST;
    cfg_local         = qcn_pkg::LOCAL_RST;
    home_cursor();

    rst_n          <= 1'b0;
    key_if.valid   <= 1'b0;
    key_if.mode    <= qcn_pkg::MODE_RESET;
    key_if.pressed <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_keys();
    test_edge_clamp();
    test_saturation();
    test_zero_factors();
    test_random_walk();
    settle();

    if (pending_pos.size() != 0) begin
      errors++;
      $display("%0t: %0d positions never arrived, expected 0 actual %0d",
               $time, pending_pos.size(), pending_pos.size());
    end
    $display("Run covered %0d acted-on keys and %0d ignored events, %0d positions checked.",
             keys_acted, keys_ignored, positions_checked);
    $display("Registers: %0d writes with readback across %0d settings; %0d errors.",
             reg_writes, settings_used, errors);
    if (errors == 0) begin
      $display("** quadrant_cursor_navigator: PASSED **");
    end else begin
      $display("** quadrant_cursor_navigator: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
design/qcn_pkg.sv
design/qcn_if.sv
design/quadrant_cursor_navigator.sv
bench/tb_top.sv
